// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, checked on every rising edge outside reset.
`define PLE_ASSERT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define PLE_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PLE_ASSERT(lbl, ante, cons)
`define PLE_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// File: rtl/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Command, status and cell operation codes of the positional list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ple_pkg;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_END   = 3'd1;
    localparam logic [2:0] CMD_INS_POS   = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_END   = 3'd4;
    localparam logic [2:0] CMD_DEL_POS   = 3'd5;
    localparam logic [2:0] CMD_SEARCH    = 3'd6;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_EMPTY  = 2'd1;
    localparam logic [1:0] ST_BADPOS = 2'd2;
    localparam logic [1:0] ST_FULL   = 2'd3;

    typedef logic [1:0] cell_op_t;

    localparam cell_op_t OP_HOLD = 2'd0;
    localparam cell_op_t OP_INS  = 2'd1;
    localparam cell_op_t OP_DEL  = 2'd2;

endpackage

// File: rtl/ple_cell.sv
// ----------------------------------------------------------------------------
// ple_cell
// One list slot: holds, loads, or takes the word of a neighbor; compares key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ple_cell
    import ple_pkg::*;
#(
    parameter int IDX = 0,
    parameter int DW  = 32,
    parameter int CW  = 5
) (
    input  logic          aclk,
    input  cell_op_t      op,
    input  logic [CW-1:0] idx,
    input  logic [CW-1:0] count,
    input  logic [DW-1:0] din,
    input  logic [DW-1:0] key,
    input  logic [DW-1:0] left_q,
    input  logic [DW-1:0] right_q,
    output logic [DW-1:0] q,
    output logic          match,
    output logic [DW-1:0] pick
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [DW-1:0] val_reg;
    logic [DW-1:0] val_next;

    always_comb begin
        val_next = val_reg;
        unique case (op)
            OP_INS: begin
                // load at the insert slot, move everything behind it back
                if (idx == MY_IDX) begin
                    val_next = din;
                end else if (MY_IDX > idx) begin
                    val_next = left_q;
                end
            end
            OP_DEL: begin
                // close the gap from the removed slot on
                if (MY_IDX >= idx) begin
                    val_next = right_q;
                end
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign q     = val_reg;
    assign match = (MY_IDX < count) && (val_reg == key);
    assign pick  = (idx == MY_IDX) ? val_reg : '0;

endmodule

// File: rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words with positional insert, delete and search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

// The list lives in a row of DEPTH cells, front at cell 0. Every command word
// is finished in the cycle it is accepted: all cells shift, hold or load in
// parallel and compare against the key in parallel, so the block takes one
// command word per clock and shows its result word in the cycle after
// acceptance. The only thing that slows input is the output register: a new
// command is taken whenever the result register is empty or being drained.
// Stored words keep the low DATA_WIDTH bits of item_value; removed_value is
// zero-extended from those bits. No clearing pass runs after reset; only the
// entry count and the result valid flag are cleared.

module positional_list_engine
    import ple_pkg::*;
#(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [2:0] cmd, [34:3] item_value, [42:35] position, [47:43] zero
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] status, [33:2] removed_value, [34] found, [39:35] entry_count
    output logic [39:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > 8) ? CW : 8;
    localparam int DW = DATA_WIDTH;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);
    localparam logic [4:0]    FULL_LO    = 5'(DEPTH);

    // input word fields
    logic [2:0]  cmd;
    logic [31:0] item_value;
    logic [7:0]  position;

    assign cmd        = s_tdata[2:0];
    assign item_value = s_tdata[34:3];
    assign position   = s_tdata[42:35];

    logic accept;
    assign accept = s_tvalid && s_tready;

    // list length
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // result register
    logic        m_tvalid_reg;
    logic        m_tvalid_next;
    logic [1:0]  status_reg;
    logic [31:0] removed_reg;
    logic        found_reg;
    logic [4:0]  entry_reg;

    // command decode
    cell_op_t      op;
    logic [CW-1:0] idx;
    logic [1:0]    status;
    logic          is_search;

    logic [PW-1:0] pos_ext;
    logic [PW-1:0] pos_m1;
    logic [PW-1:0] count_ext;
    logic [CW-1:0] ins_idx;
    logic          empty;
    logic          full;

    logic [63:0]   val64;
    logic [DW-1:0] key;

    // cell row wiring
    logic [DW-1:0] cell_q    [DEPTH];
    logic [DW-1:0] cell_pick [DEPTH];
    logic [DEPTH-1:0] cell_match;
    logic [DW-1:0] picked;
    logic          any_match;

    logic [63:0]   rem64;
    logic [31:0]   removed;
    logic          found;
    logic [31:0]   cnt32;

    assign val64 = {32'b0, item_value};
    assign key   = val64[DW-1:0];

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == FULL_COUNT);
    assign pos_ext   = PW'(position);
    assign pos_m1    = pos_ext - PW'(1);
    assign count_ext = PW'(count_reg);
    // past the end appends
    assign ins_idx   = (pos_m1 > count_ext) ? count_reg : pos_m1[CW-1:0];

    always_comb begin
        op        = OP_HOLD;
        idx       = '0;
        status    = ST_OK;
        is_search = 1'b0;
        unique case (cmd)
            CMD_INS_FRONT: begin
                if (full) begin
                    status = ST_FULL;
                end else begin
                    op = OP_INS;
                end
            end
            CMD_INS_END: begin
                idx = count_reg;
                if (full) begin
                    status = ST_FULL;
                end else begin
                    op = OP_INS;
                end
            end
            CMD_INS_POS: begin
                idx = ins_idx;
                // position check comes before the full check
                if (position == 8'd0 || empty) begin
                    status = ST_BADPOS;
                end else if (full) begin
                    status = ST_FULL;
                end else begin
                    op = OP_INS;
                end
            end
            CMD_DEL_FRONT: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    op = OP_DEL;
                end
            end
            CMD_DEL_END: begin
                idx = count_reg - CW'(1);
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    op = OP_DEL;
                end
            end
            CMD_DEL_POS: begin
                idx = pos_m1[CW-1:0];
                if (empty) begin
                    status = ST_EMPTY;
                end else if (position == 8'd0 || pos_m1 >= count_ext) begin
                    status = ST_BADPOS;
                end else begin
                    op = OP_DEL;
                end
            end
            CMD_SEARCH: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else begin
                    is_search = 1'b1;
                end
            end
            default: begin
                op = OP_HOLD;
            end
        endcase
        // cells move only on an accepted word
        if (!accept) begin
            op = OP_HOLD;
        end
    end

    // row of cells; each takes from its left neighbor on insert and its
    // right neighbor on delete
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DW-1:0] left_q;
        logic [DW-1:0] right_q;

        if (i == 0) begin : g_first
            assign left_q = '0;
        end else begin : g_left
            assign left_q = cell_q[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_q = '0;
        end else begin : g_right
            assign right_q = cell_q[i+1];
        end

        ple_cell #(
            .IDX (i),
            .DW  (DW),
            .CW  (CW)
        ) u_cell (
            .aclk    (aclk),
            .op      (op),
            .idx     (idx),
            .count   (count_reg),
            .din     (key),
            .key     (key),
            .left_q  (left_q),
            .right_q (right_q),
            .q       (cell_q[i]),
            .match   (cell_match[i]),
            .pick    (cell_pick[i])
        );
    end

    // one-hot AND-OR gather of the slot being removed
    always_comb begin
        picked = '0;
        for (int k = 0; k < DEPTH; k++) begin
            picked = picked | cell_pick[k];
        end
    end

    assign any_match = |cell_match;

    always_comb begin
        rem64         = '0;
        rem64[DW-1:0] = picked;
    end

    assign removed = (op == OP_DEL) ? rem64[31:0] : 32'd0;
    assign found   = is_search && any_match;

    always_comb begin
        unique case (op)
            OP_INS:  count_next = count_reg + CW'(1);
            OP_DEL:  count_next = count_reg - CW'(1);
            default: count_next = count_reg;
        endcase
    end

    assign cnt32 = 32'(count_next);

    // hold the result until taken; accept the next word as it drains,
    // and take nothing while reset is held
    assign s_tready = aresetn && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg  <= status;
            removed_reg <= removed;
            found_reg   <= found;
            entry_reg   <= cnt32[4:0];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {entry_reg, found_reg, removed_reg, status_reg};

    // checks
    `PLE_ASSERT(a_count_bound, 1'b1, count_reg <= FULL_COUNT)
    `PLE_ASSERT_NEXT(a_ins_grows, op == OP_INS, count_reg == $past(count_reg) + CW'(1))
    `PLE_ASSERT(a_full_count, m_tvalid_reg && status_reg == ST_FULL, entry_reg == FULL_LO)
    `PLE_ASSERT(a_found_ok, m_tvalid_reg && found_reg, status_reg == ST_OK)
    `PLE_ASSERT(a_removed_ok, m_tvalid_reg && removed_reg != 32'd0, status_reg == ST_OK)

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_list_engine. A scoreboard keeps its own
// copy of the list, predicts the result word of every accepted command word
// and checks each result word as it is drained. A short directed part walks
// the empty, invalid position, append and full cases. A random part follows:
// it alternates growing and shrinking phases so that the list often sits at
// full and at empty. Both sides of the block idle at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
    import ple_pkg::*;

    localparam int          LIST_DEPTH   = 16;
    localparam int          RANDOM_WORDS = 600;
    localparam int          MAX_REPORTS  = 10;
    // Code seven has no meaning; the block must leave the list alone.
    localparam logic [2:0]  CMD_UNUSED   = 3'd7;

    // Result word as it sits on m_tdata, last field in the lowest bits.
    typedef struct packed {
        logic [4:0]  entry_count;
        logic        found;
        logic [31:0] removed_value;
        logic [1:0]  status;
    } result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow list, predicted result words, mismatch count.
    // ------------------------------------------------------------------------
    class list_scoreboard;
        logic [31:0] entries [LIST_DEPTH];
        int unsigned count;
        result_t     expected_q [$];
        int          mismatches;

        function new();
            count      = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Insert at a 0-based slot; a slot past the count appends.
        function logic [1:0] insert_at(int unsigned idx, logic [31:0] val);
            int unsigned i;
            if (count >= LIST_DEPTH) return ST_FULL;
            if (idx > count) idx = count;
            for (i = count; i > idx; i--) entries[i] = entries[i - 1];
            entries[idx] = val;
            count++;
            return ST_OK;
        endfunction

        function logic [1:0] remove_at(int unsigned idx, output logic [31:0] removed);
            int unsigned i;
            removed = '0;
            if (count == 0) return ST_EMPTY;
            if (idx >= count) return ST_BADPOS;
            removed = entries[idx];
            for (i = idx; i + 1 < count; i++) entries[i] = entries[i + 1];
            count--;
            return ST_OK;
        endfunction

        // Note one accepted command word and queue the result it must cause.
        function void note_command(logic [2:0] cmd, logic [31:0] val, logic [7:0] pos);
            result_t     want;
            logic [31:0] removed;
            int unsigned i;
            want    = '0;
            removed = '0;
            case (cmd)
                CMD_INS_FRONT: want.status = insert_at(0, val);
                CMD_INS_END:   want.status = insert_at(count, val);
                CMD_INS_POS: begin
                    if (pos == 0 || count == 0) want.status = ST_BADPOS;
                    else want.status = insert_at(pos - 1, val);
                end
                CMD_DEL_FRONT: want.status = remove_at(0, removed);
                CMD_DEL_END: begin
                    if (count == 0) want.status = ST_EMPTY;
                    else want.status = remove_at(count - 1, removed);
                end
                CMD_DEL_POS: begin
                    if (count == 0) want.status = ST_EMPTY;
                    else if (pos == 0) want.status = ST_BADPOS;
                    else want.status = remove_at(pos - 1, removed);
                end
                CMD_SEARCH: begin
                    if (count == 0) want.status = ST_EMPTY;
                    for (i = 0; i < count; i++)
                        if (entries[i] == val) want.found = 1'b1;
                end
                default: want.status = ST_OK;
            endcase
            if (want.status == ST_OK) want.removed_value = removed;
            want.entry_count = count[4:0];
            expected_q.push_back(want);
        endfunction

        // Check one drained result word against the oldest prediction.
        function void check_result(logic [39:0] word);
            result_t got;
            result_t want;
            got = word;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result word %h with nothing predicted", $realtime, word);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.removed_value !== want.removed_value ||
                got.found !== want.found || got.entry_count !== want.entry_count) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display({"[%0t] mismatch exp/act: status %0d/%0d removed %h/%h",
                              " found %0d/%0d count %0d/%0d"},
                             $realtime, want.status, got.status, want.removed_value,
                             got.removed_value, want.found, got.found,
                             want.entry_count, got.entry_count);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset and the block
    // ------------------------------------------------------------------------
    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    list_scoreboard sb;
    bit             tx_calm;
    bit             rx_calm;
    bit             growing;

    always #10 aclk = ~aclk;

    positional_list_engine #(
        .DEPTH      (LIST_DEPTH),
        .DATA_WIDTH (32)
    ) i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // ------------------------------------------------------------------------
    // Command side
    // ------------------------------------------------------------------------

    // Offer one command word after a random gap and hold it until taken.
    // The valid stays high across back-to-back words; it is lowered only
    // when a gap follows.
    task automatic send_command(input logic [2:0] cmd, input logic [31:0] val,
                                input logic [7:0] pos);
        int gap;
        if ($urandom_range(0, 39) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 15);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, pos, val, cmd};
        do @(posedge aclk); while (!s_tready);
        // Note it here so the next word is chosen from an up-to-date list.
        sb.note_command(cmd, val, pos);
    endtask

    // Mix of extremes, a tiny pool that makes duplicates, and full randoms.
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            4, 5:    return $urandom_range(0, 7);
            default: return $urandom;
        endcase
    endfunction

    // One random command word, biased by the current phase.
    task automatic send_random_command();
        int          roll;
        logic [2:0]  cmd;
        logic [31:0] val;
        logic [7:0]  pos;
        if ($urandom_range(0, 29) == 0) growing = !growing;
        roll = $urandom_range(0, 99);
        if (roll < (growing ? 70 : 20)) begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_INS_FRONT;
                1:       cmd = CMD_INS_END;
                default: cmd = CMD_INS_POS;
            endcase
        end else if (roll < (growing ? 85 : 75)) begin
            case ($urandom_range(0, 2))
                0:       cmd = CMD_DEL_FRONT;
                1:       cmd = CMD_DEL_END;
                default: cmd = CMD_DEL_POS;
            endcase
        end else if (roll < 98) begin
            cmd = CMD_SEARCH;
        end else begin
            cmd = CMD_UNUSED;
        end
        // Mostly positions near the count, sometimes anywhere in the byte.
        if ($urandom_range(0, 9) < 7) pos = 8'($urandom_range(0, sb.count + 2));
        else pos = 8'($urandom_range(0, 255));
        // Searches often hit a live entry.
        if (cmd == CMD_SEARCH && sb.count > 0 && $urandom_range(0, 1) == 1)
            val = sb.entries[$urandom_range(0, sb.count - 1)];
        else
            val = pick_value();
        send_command(cmd, val, pos);
    endtask

    // ------------------------------------------------------------------------
    // Result side: drain result words with random stalls and check each one.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if ($urandom_range(0, 39) == 0) rx_calm = !rx_calm;
            gap = rx_calm ? 0 : $urandom_range(0, 15);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int n;
        sb       = new();
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        m_tready = 1'b0;
        tx_calm  = 1'b0;
        rx_calm  = 1'b0;
        growing  = 1'b1;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Commands on an empty list: empty status, invalid position, or the unused code.
        send_command(CMD_SEARCH,    32'h0000_0000, 8'd0);
        send_command(CMD_DEL_FRONT, 32'hFFFF_FFFF, 8'd0);
        send_command(CMD_DEL_END,   32'h0000_0000, 8'd255);
        send_command(CMD_DEL_POS,   32'h0000_0000, 8'd0);
        send_command(CMD_INS_POS,   32'h1234_5678, 8'd1);
        send_command(CMD_UNUSED,    32'hFFFF_FFFF, 8'd255);
        // Build a short list with the extreme values.
        send_command(CMD_INS_FRONT, 32'h7FFF_FFFF, 8'd0);
        send_command(CMD_INS_END,   32'h8000_0000, 8'd0);
        send_command(CMD_INS_POS,   32'h0000_0000, 8'd1);
        send_command(CMD_INS_POS,   32'hFFFF_FFFF, 8'd255);
        send_command(CMD_INS_POS,   32'hDEAD_BEEF, 8'd0);
        send_command(CMD_INS_POS,   32'h0000_3039, 8'd2);
        send_command(CMD_SEARCH,    32'h8000_0000, 8'd0);
        send_command(CMD_SEARCH,    32'h0000_0001, 8'd0);
        send_command(CMD_UNUSED,    32'h0000_0000, 8'd0);
        // Deletes: bad positions, then one of each kind.
        send_command(CMD_DEL_POS,   32'h0000_0000, 8'd0);
        send_command(CMD_DEL_POS,   32'h0000_0000, 8'd255);
        send_command(CMD_DEL_POS,   32'h0000_0000, 8'd2);
        send_command(CMD_DEL_FRONT, 32'h0000_0000, 8'd0);
        send_command(CMD_DEL_END,   32'h0000_0000, 8'd0);
        // Fill to full and try twice more.
        while (sb.count < LIST_DEPTH) send_command(CMD_INS_END, $urandom, 8'd0);
        send_command(CMD_INS_FRONT, 32'h5555_AAAA, 8'd0);
        send_command(CMD_INS_POS,   32'hAAAA_5555, 8'd3);

        for (n = 0; n < RANDOM_WORDS; n++) send_random_command();
        s_tvalid <= 1'b0;

        // Drain, then leave room for a stray result word to show up.
        while (sb.pending() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
